// ----- rtl/core/cvalu_pkg.sv -----
// Shared types, constants and checking functions for the checked integer vector ALU.
package cvalu_pkg;

    // Arithmetic width; operands are taken as their low DATA_WIDTH bits, sign-extended.
    localparam int DATA_WIDTH = 64;
    localparam int XLEN       = 64;

    localparam logic [XLEN-1:0] WMASK   = {XLEN{1'b1}} >> (XLEN - DATA_WIDTH);
    localparam logic [XLEN-1:0] WSIGN   = {{(XLEN-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1);
    localparam logic [XLEN-1:0] WMAXPOS = WMASK >> 1;

    // Multiplier works on half-width slices.
    localparam int HALF = XLEN / 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALAR    = 2'd2;

    // Command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_SUB     = 2'd1,
        OP_MUL     = 2'd2,
        OP_ADD_ALT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        MODE_ELEM         = 3'd0,
        MODE_SCALAR_LEFT  = 3'd1,
        MODE_SCALAR_RIGHT = 3'd2,
        MODE_FOLD         = 3'd3,
        MODE_SUFFIX_SCAN  = 3'd4,
        MODE_PREFIX_SCAN  = 3'd5,
        MODE_DOT          = 3'd6,
        MODE_SCALED_ACC   = 3'd7
    } t_mode;

    // What the back end does with one item.
    typedef enum logic [1:0] {
        K_ADD = 2'd0,
        K_SUB = 2'd1,
        K_MUL = 2'd2,
        K_MAC = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MS_IDLE = 2'd0,
        MS_PART = 2'd1,
        MS_FIX  = 2'd2,
        MS_DONE = 2'd3
    } t_mstate;

    typedef struct packed {
        logic [XLEN-1:0] val_a;
        logic [XLEN-1:0] val_b;
        logic [XLEN-1:0] val_c;
        t_kind           kind;
        logic            a_acc;
        logic            b_acc;
        logic            c_acc;
        logic            alt;
        logic            accum;
        logic            emit_all;
        logic            init_one;
        logic            last;
    } t_cmd;

    function automatic logic [XLEN-1:0] sext_w(input logic [XLEN-1:0] v);
        return ((v & WMASK) ^ WSIGN) - WSIGN;
    endfunction

    function automatic logic add_ovf(input logic [XLEN-1:0] a, input logic [XLEN-1:0] b,
                                     input logic [XLEN-1:0] s);
        logic [XLEN-1:0] t;
        t = (a ^ s) & (b ^ s);
        return t[XLEN-1] || (sext_w(s) != s);
    endfunction

    function automatic logic sub_ovf(input logic [XLEN-1:0] a, input logic [XLEN-1:0] b,
                                     input logic [XLEN-1:0] s);
        logic [XLEN-1:0] t;
        t = (a ^ b) & (a ^ s);
        return t[XLEN-1] || (sext_w(s) != s);
    endfunction

endpackage

// ----- rtl/core/checked_integer_vector_alu_top.sv -----
// Top level of the checked integer vector ALU: front end, command queue and back end.
// Add and subtract items, in every mode, go through at one item per clock cycle while no multiply
// is under way and no result is held back. Items that multiply (operation multiply, dot product,
// scaled accumulate) are worked in steps in the back end: the operand magnitudes are registered,
// then the 64 by 64 bit product is built from four 32 by 32 bit partial products on one shared
// multiplier, followed by a range check and the final add. A two-entry command queue lets the
// input keep taking items while the back end works. An output register holds each result until
// it is taken; while a result waits the back end completes no further item, though a multiply
// already under way runs on. Items dropped after an overflow produce no result.
module checked_integer_vector_alu_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cvalu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cvalu_pkg::XLEN-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [cvalu_pkg::XLEN-1:0]          i_first_operand,
    input  logic [cvalu_pkg::XLEN-1:0]          i_second_operand,
    input  logic                                i_last_element,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [cvalu_pkg::XLEN-1:0]          o_value,
    output logic                                o_overflowed,
    output logic                                o_end_of_vector
);

    cvalu_pkg::t_cmd front_cmd;
    cvalu_pkg::t_cmd head_cmd;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            push;

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    cvalu_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_cfg_ready      (o_cfg_ready),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_last_element   (i_last_element),
        .o_cmd            (front_cmd)
    );

    cvalu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_cmd),
        .i_pop   (q_pop)
    );

    cvalu_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head_valid        (q_valid),
        .i_head              (head_cmd),
        .o_pop               (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_value         (o_value),
        .o_out_overflowed    (o_overflowed),
        .o_out_end_of_vector (o_end_of_vector)
    );

endmodule

// ----- rtl/core/cvalu_front.sv -----
// Front end: configuration registers and decoding of each item into a back-end command.
module cvalu_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [cvalu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cvalu_pkg::XLEN-1:0]          i_cfg_data,
    output logic                                o_cfg_ready,
    input  logic [cvalu_pkg::XLEN-1:0]          i_first_operand,
    input  logic [cvalu_pkg::XLEN-1:0]          i_second_operand,
    input  logic                                i_last_element,
    output cvalu_pkg::t_cmd                     o_cmd
);

    cvalu_pkg::t_op             r_operation;
    cvalu_pkg::t_mode           r_mode;
    logic [cvalu_pkg::XLEN-1:0] r_scalar;

    logic [cvalu_pkg::XLEN-1:0] x;
    logic [cvalu_pkg::XLEN-1:0] y;
    logic [cvalu_pkg::XLEN-1:0] u;
    cvalu_pkg::t_kind           op_kind;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation <= cvalu_pkg::OP_ADD;
            r_mode      <= cvalu_pkg::MODE_ELEM;
            r_scalar    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cvalu_pkg::CFG_OPERATION: r_operation <= cvalu_pkg::t_op'(i_cfg_data[1:0]);
                cvalu_pkg::CFG_MODE:      r_mode      <= cvalu_pkg::t_mode'(i_cfg_data[2:0]);
                cvalu_pkg::CFG_SCALAR:    r_scalar    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        x = cvalu_pkg::sext_w(i_first_operand);
        y = cvalu_pkg::sext_w(i_second_operand);
        u = cvalu_pkg::sext_w(r_scalar);

        unique case (r_operation)
            cvalu_pkg::OP_SUB: op_kind = cvalu_pkg::K_SUB;
            cvalu_pkg::OP_MUL: op_kind = cvalu_pkg::K_MUL;
            default:           op_kind = cvalu_pkg::K_ADD;
        endcase

        o_cmd          = '0;
        o_cmd.val_a    = x;
        o_cmd.val_b    = y;
        o_cmd.val_c    = x;
        o_cmd.kind     = op_kind;
        o_cmd.emit_all = 1'b1;
        o_cmd.last     = i_last_element;

        unique case (r_mode)
            cvalu_pkg::MODE_ELEM: ;
            cvalu_pkg::MODE_SCALAR_LEFT:  o_cmd.val_a = u;
            cvalu_pkg::MODE_SCALAR_RIGHT: o_cmd.val_b = u;
            cvalu_pkg::MODE_FOLD, cvalu_pkg::MODE_SUFFIX_SCAN: begin
                // Subtract in a right fold is x minus the running value.
                if (r_operation == cvalu_pkg::OP_SUB) begin
                    o_cmd.b_acc = 1'b1;
                end else begin
                    o_cmd.a_acc = 1'b1;
                    o_cmd.val_b = x;
                end
                o_cmd.accum    = 1'b1;
                o_cmd.emit_all = (r_mode == cvalu_pkg::MODE_SUFFIX_SCAN);
                o_cmd.init_one = (r_operation == cvalu_pkg::OP_MUL);
            end
            cvalu_pkg::MODE_PREFIX_SCAN: begin
                o_cmd.a_acc    = 1'b1;
                o_cmd.val_b    = x;
                o_cmd.accum    = 1'b1;
                o_cmd.init_one = (r_operation == cvalu_pkg::OP_MUL);
                // Subtract alternates: even positions add, odd positions subtract.
                if (r_operation == cvalu_pkg::OP_SUB) begin
                    o_cmd.kind = cvalu_pkg::K_ADD;
                    o_cmd.alt  = 1'b1;
                end
            end
            cvalu_pkg::MODE_DOT: begin
                o_cmd.kind     = cvalu_pkg::K_MAC;
                o_cmd.c_acc    = 1'b1;
                o_cmd.accum    = 1'b1;
                o_cmd.emit_all = 1'b0;
            end
            cvalu_pkg::MODE_SCALED_ACC: begin
                o_cmd.kind  = cvalu_pkg::K_MAC;
                o_cmd.val_a = u;
            end
        endcase
    end

endmodule

// ----- rtl/core/cvalu_queue.sv -----
// Short command queue that decouples the front end from the back end.
module cvalu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cvalu_pkg::t_cmd i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output cvalu_pkg::t_cmd o_head,
    input  logic            i_pop
);

    cvalu_pkg::t_cmd                   r_mem [cvalu_pkg::QDEPTH];
    logic [cvalu_pkg::QPTR_W-1:0]      r_wptr;
    logic [cvalu_pkg::QPTR_W-1:0]      r_rptr;
    logic [cvalu_pkg::QCNT_W-1:0]      r_count;

    assign o_full  = (r_count == cvalu_pkg::QCNT_W'(cvalu_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Depth is a power of two, so the pointers wrap on their own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/cvalu_back.sv -----
// Back end: vector state, checked add/subtract, iterative checked multiply and output register.
module cvalu_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_head_valid,
    input  cvalu_pkg::t_cmd            i_head,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [cvalu_pkg::XLEN-1:0] o_out_value,
    output logic                       o_out_overflowed,
    output logic                       o_out_end_of_vector
);

    localparam int XLEN = cvalu_pkg::XLEN;
    localparam int HALF = cvalu_pkg::HALF;

    // Vector state
    logic [XLEN-1:0]     r_acc, n_acc;
    logic                r_at_start, n_at_start;
    logic                r_odd, n_odd;
    logic                r_dropping, n_dropping;

    // Multiplier state
    cvalu_pkg::t_mstate  r_mstate, n_mstate;
    logic [1:0]          r_pp, n_pp;
    logic [XLEN-1:0]     r_ma, n_ma;
    logic [XLEN-1:0]     r_mb, n_mb;
    logic                r_mneg, n_mneg;
    logic [2*XLEN-1:0]   r_prod, n_prod;
    logic [XLEN-1:0]     r_t, n_t;
    logic                r_tbad, n_tbad;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [XLEN-1:0]     r_out_value, n_out_value;
    logic                r_out_ovf, n_out_ovf;
    logic                r_out_eov, n_out_eov;

    logic [XLEN-1:0]     acc_eff;
    logic                odd_eff;
    logic [XLEN-1:0]     opa, opb, opc;
    logic                use_sub;
    logic [XLEN-1:0]     as_sum;
    logic                as_bad;
    logic                is_mul;
    logic                out_free;
    logic                commit;
    logic [XLEN-1:0]     v;
    logic                bad;
    logic [HALF-1:0]     a_half, b_half;
    logic [XLEN-1:0]     pp;
    logic [6:0]          sh;
    logic [XLEN-1:0]     limit;
    logic [XLEN-1:0]     mac_sum;

    assign o_out_valid         = r_out_valid;
    assign o_out_value         = r_out_value;
    assign o_out_overflowed    = r_out_ovf;
    assign o_out_end_of_vector = r_out_eov;

    always_comb begin
        // The first item of a vector sees a freshly seeded accumulator.
        acc_eff = r_at_start ? (i_head.init_one ? XLEN'(1) : '0) : r_acc;
        odd_eff = r_at_start ? 1'b0 : r_odd;
        opa     = i_head.a_acc ? acc_eff : i_head.val_a;
        opb     = i_head.b_acc ? acc_eff : i_head.val_b;
        opc     = i_head.c_acc ? acc_eff : i_head.val_c;
        use_sub = (i_head.kind == cvalu_pkg::K_SUB) || (i_head.alt && odd_eff);
        is_mul  = (i_head.kind == cvalu_pkg::K_MUL) || (i_head.kind == cvalu_pkg::K_MAC);
        if (use_sub) begin
            as_sum = opa - opb;
            as_bad = cvalu_pkg::sub_ovf(opa, opb, as_sum);
        end else begin
            as_sum = opa + opb;
            as_bad = cvalu_pkg::add_ovf(opa, opb, as_sum);
        end

        // Partial product r_pp: bit 0 picks the half of a, bit 1 the half of b.
        a_half  = r_pp[0] ? r_ma[XLEN-1:HALF] : r_ma[HALF-1:0];
        b_half  = r_pp[1] ? r_mb[XLEN-1:HALF] : r_mb[HALF-1:0];
        pp      = XLEN'(a_half) * XLEN'(b_half);
        sh      = {r_pp[0] & r_pp[1], r_pp[0] ^ r_pp[1], 5'b0};
        limit   = r_mneg ? cvalu_pkg::WMAXPOS + 1'b1 : cvalu_pkg::WMAXPOS;
        mac_sum = opc + r_t;

        out_free = !r_out_valid || !i_out_stall;

        n_acc       = r_acc;
        n_at_start  = r_at_start;
        n_odd       = r_odd;
        n_dropping  = r_dropping;
        n_mstate    = r_mstate;
        n_pp        = r_pp;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_mneg      = r_mneg;
        n_prod      = r_prod;
        n_t         = r_t;
        n_tbad      = r_tbad;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_ovf   = r_out_ovf;
        n_out_eov   = r_out_eov;
        o_pop       = 1'b0;
        commit      = 1'b0;
        v           = '0;
        bad         = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_mstate)
            cvalu_pkg::MS_IDLE: begin
                if (i_head_valid) begin
                    if (r_dropping) begin
                        // After an overflow the rest of the vector is discarded.
                        o_pop = 1'b1;
                        if (i_head.last) begin
                            n_dropping = 1'b0;
                            n_at_start = 1'b1;
                            n_odd      = 1'b0;
                        end
                    end else if (is_mul) begin
                        n_ma     = opa[XLEN-1] ? -opa : opa;
                        n_mb     = opb[XLEN-1] ? -opb : opb;
                        n_mneg   = opa[XLEN-1] ^ opb[XLEN-1];
                        n_prod   = '0;
                        n_pp     = '0;
                        n_mstate = cvalu_pkg::MS_PART;
                    end else if (out_free) begin
                        commit = 1'b1;
                        v      = as_sum;
                        bad    = as_bad;
                    end
                end
            end
            cvalu_pkg::MS_PART: begin
                n_prod = r_prod + ({{XLEN{1'b0}}, pp} << sh);
                n_pp   = r_pp + 1'b1;
                if (r_pp == 2'd3) begin
                    n_mstate = cvalu_pkg::MS_FIX;
                end
            end
            cvalu_pkg::MS_FIX: begin
                n_tbad   = (r_prod[2*XLEN-1:XLEN] != '0) || (r_prod[XLEN-1:0] > limit);
                n_t      = r_mneg ? -r_prod[XLEN-1:0] : r_prod[XLEN-1:0];
                n_mstate = cvalu_pkg::MS_DONE;
            end
            cvalu_pkg::MS_DONE: begin
                if (out_free) begin
                    commit   = 1'b1;
                    n_mstate = cvalu_pkg::MS_IDLE;
                    if (i_head.kind == cvalu_pkg::K_MAC) begin
                        v   = r_tbad ? '0 : mac_sum;
                        bad = r_tbad || cvalu_pkg::add_ovf(opc, r_t, mac_sum);
                    end else begin
                        v   = r_t;
                        bad = r_tbad;
                    end
                end
            end
        endcase

        if (commit) begin
            o_pop      = 1'b1;
            n_acc      = bad ? '0 : (i_head.accum ? v : acc_eff);
            n_odd      = !odd_eff;
            n_at_start = i_head.last;
            n_dropping = bad && !i_head.last;
            if (bad || i_head.emit_all || i_head.last) begin
                n_out_valid = 1'b1;
                n_out_value = bad ? '0 : v;
                n_out_ovf   = bad;
                n_out_eov   = bad || i_head.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_at_start  <= 1'b1;
            r_odd       <= 1'b0;
            r_dropping  <= 1'b0;
            r_mstate    <= cvalu_pkg::MS_IDLE;
            r_pp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_at_start  <= n_at_start;
            r_odd       <= n_odd;
            r_dropping  <= n_dropping;
            r_mstate    <= n_mstate;
            r_pp        <= n_pp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma        <= n_ma;
        r_mb        <= n_mb;
        r_mneg      <= n_mneg;
        r_prod      <= n_prod;
        r_t         <= n_t;
        r_tbad      <= n_tbad;
        r_out_value <= n_out_value;
        r_out_ovf   <= n_out_ovf;
        r_out_eov   <= n_out_eov;
    end

endmodule

// ----- rtl/core/cvalu_checker.sv -----
// Port-level checks for the checked integer vector ALU, bound to the top level.
module cvalu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [cvalu_pkg::XLEN-1:0]  o_value,
    input logic                        o_overflowed,
    input logic                        o_end_of_vector
);

    // An overflow result carries a zero value and closes the vector.
    a_overflow_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflowed) |-> (o_value == '0) && o_end_of_vector)
        else $error("overflow result must be zero and end the vector");

    // A result that is held back stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_value)
            && $stable(o_overflowed) && $stable(o_end_of_vector))
        else $error("stalled result changed");

    // Reset leaves no result pending and an empty queue.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear output or queue");

endmodule

bind checked_integer_vector_alu_top cvalu_checker u_cvalu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_value         (o_value),
    .o_overflowed    (o_overflowed),
    .o_end_of_vector (o_end_of_vector)
);
